// ----- rtl/core/rrs_pkg.sv -----
// Shared constants and types for the round-robin schedule simulator.
package rrs_pkg;
  localparam int unsigned MaxProcsDefault = 16;
  localparam int unsigned TimeW = 24;
  localparam int unsigned ArrW = 16;
  localparam int unsigned BurstW = 16;
  localparam int unsigned QuantW = 16;
  localparam int unsigned PidW = 4;
  localparam logic [QuantW-1:0] QuantumReset = 16'd4;

  typedef struct packed {
    logic [ArrW-1:0]   arrival_time;
    logic [BurstW-1:0] burst_time;
    logic              last_process;
  } req_t;

  typedef struct packed {
    logic [PidW-1:0]  process_id;
    logic [TimeW-1:0] waiting_time;
    logic [TimeW-1:0] turnaround_time;
    logic             last_result;
    logic             overflow;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // store incoming request
    logic sort_init;  // start insertion step i: v = i, j = i
    logic sort_shift; // order[j] = order[j-1], j--
    logic sort_place; // order[j] = v, i++
    logic enq;        // queue order[i], i++
    logic deq;        // dispatch head entry
    logic emit_init;  // i = 0 before sort, enqueue and emission
    logic emit_next;  // i++
    logic clear;      // clear job state
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sort_done;  // i == n
    logic ins_go;     // j > 0 and v goes before order[j-1]
    logic enq_done;   // i == n
    logic q_empty;
    logic emit_last;  // i + 1 == n
    logic empty_job;  // n == 0
  } sts_t;
endpackage

// ----- rtl/core/rrs_if.sv -----
// Valid/ready channel carrying one payload.
interface rrs_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/round_robin_schedule_sim.sv -----
// Top level of the round-robin schedule simulator.
// Usage:
//   in_req is a valid/ready request channel, one process per request
//   (arrival_time, burst_time, last_process). Requests load one per cycle.
//   A request with last_process set closes the job. For N loaded processes
//   the insertion sort makes at most N*(N-1)/2 shifts, then the sorted
//   processes are queued and run. Each dispatch either finishes a process
//   or runs one quantum and requeues it at the tail of the run queue.
//   Results follow on out_rsp in load order, one per cycle while the sink
//   takes them; the last carries last_result. A stalled sink holds the
//   current result stable and the block waits. No request is taken from
//   the last one until the final result is delivered. Processes beyond
//   MaxProcs are dropped and flag overflow on every result of the job.
//   cfg_we_i/cfg_wdata_i write time_quantum (reset 4; zero acts as one);
//   write it only while idle. Reset clears the job and returns to loading.
module round_robin_schedule_sim #(
  parameter int unsigned MaxProcs = rrs_pkg::MaxProcsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rrs_pkg::QuantW-1:0] cfg_wdata_i,
  rrs_if.sink                        in_req,
  rrs_if.source                      out_rsp
);
  import rrs_pkg::*;

  logic [QuantW-1:0] quantum_q;
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  // Hold the quantum register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quantum_q <= QuantumReset;
    else if (cfg_we_i) quantum_q <= cfg_wdata_i;
  end

  rrs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_req.valid),
    .in_last_i  (in_req.data.last_process),
    .in_ready_o (in_req.ready),
    .out_valid_o(out_rsp.valid),
    .out_ready_i(out_rsp.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrs_dp #(.MaxProcs(MaxProcs)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i    (cmd),
    .req_i    (in_req.data),
    .quantum_i(quantum_q),
    .sts_o    (sts),
    .rsp_o    (rsp)
  );

  assign out_rsp.data = rsp;
endmodule

// ----- rtl/core/rrs_dp.sv -----
// Datapath: process tables, sort order, run queue, clock and result fields.
module rrs_dp #(
  parameter int unsigned MaxProcs = rrs_pkg::MaxProcsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rrs_pkg::cmd_t              cmd_i,
  input  rrs_pkg::req_t              req_i,
  input  logic [rrs_pkg::QuantW-1:0] quantum_i,
  output rrs_pkg::sts_t              sts_o,
  output rrs_pkg::rsp_t              rsp_o
);
  import rrs_pkg::*;
  localparam int unsigned IdxW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned CntW = $clog2(MaxProcs + 1);

  logic [ArrW-1:0]   arr_q   [MaxProcs];
  logic [BurstW-1:0] rem_q   [MaxProcs];
  logic [TimeW-1:0]  rdy_q   [MaxProcs];
  logic [TimeW-1:0]  wait_q  [MaxProcs];
  logic [TimeW-1:0]  tat_q   [MaxProcs];
  logic [IdxW-1:0]   order_q [MaxProcs];
  logic [IdxW-1:0]   rq_q    [MaxProcs];
  logic [IdxW-1:0]   head_q;
  logic [CntW-1:0]   qcnt_q, n_q, i_q, j_q;
  logic [IdxW-1:0]   v_q;
  logic [TimeW-1:0]  clk_q;
  logic              ovf_q;

  logic [IdxW-1:0] i_idx, jm1, id, prev, tail, head_nxt;
  logic [CntW:0]   tail_sum;
  logic            goes_first;
  logic [BurstW-1:0] q_eff;
  logic [TimeW-1:0]  start_t, end_t;
  logic              fin;

  always_comb begin
    i_idx = i_q[IdxW-1:0];
    jm1   = IdxW'(j_q - CntW'(1));
    prev  = order_q[jm1];
    if (arr_q[v_q] != arr_q[prev]) goes_first = arr_q[v_q] < arr_q[prev];
    else if (rem_q[v_q] != rem_q[prev]) goes_first = rem_q[v_q] < rem_q[prev];
    else goes_first = v_q < prev;
    id       = rq_q[head_q];
    // head < MaxProcs and count <= MaxProcs, so one subtract wraps the tail.
    tail_sum = (CntW + 1)'(head_q) + (CntW + 1)'(qcnt_q);
    tail     = (tail_sum >= (CntW + 1)'(MaxProcs)) ?
               IdxW'(tail_sum - (CntW + 1)'(MaxProcs)) : IdxW'(tail_sum);
    head_nxt = ((CntW'(head_q) + CntW'(1)) == CntW'(MaxProcs)) ? '0 : head_q + IdxW'(1);
    q_eff   = (quantum_i == '0) ? BurstW'(1) : quantum_i;
    start_t = (clk_q > rdy_q[id]) ? clk_q : rdy_q[id];
    fin     = rem_q[id] <= q_eff;
    end_t   = start_t + TimeW'(fin ? rem_q[id] : q_eff);
  end

  assign sts_o.sort_done = (i_q == n_q);
  assign sts_o.ins_go    = (j_q != '0) && goes_first;
  assign sts_o.enq_done  = (i_q == n_q);
  assign sts_o.q_empty   = (qcnt_q == '0);
  assign sts_o.emit_last = (CntW'(i_q + CntW'(1)) == n_q);
  assign sts_o.empty_job = (n_q == '0);

  assign rsp_o.process_id      = PidW'(i_q);
  assign rsp_o.waiting_time    = wait_q[i_idx];
  assign rsp_o.turnaround_time = tat_q[i_idx];
  assign rsp_o.last_result     = sts_o.emit_last;
  assign rsp_o.overflow        = ovf_q;

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0; i_q <= '0; j_q <= '0; qcnt_q <= '0; head_q <= '0;
      clk_q <= '0; ovf_q <= 1'b0; v_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (n_q == CntW'(MaxProcs)) ovf_q <= 1'b1;
        else n_q <= n_q + CntW'(1);
      end
      if (cmd_i.sort_init) begin
        v_q <= i_idx; j_q <= i_q;
      end
      if (cmd_i.sort_shift) j_q <= j_q - CntW'(1);
      if (cmd_i.sort_place || cmd_i.enq || cmd_i.emit_next) i_q <= i_q + CntW'(1);
      if (cmd_i.emit_init) i_q <= '0;
      if (cmd_i.enq) qcnt_q <= qcnt_q + CntW'(1);
      if (cmd_i.deq) begin
        head_q <= head_nxt;
        if (fin) qcnt_q <= qcnt_q - CntW'(1);
        clk_q <= end_t;
      end
      if (cmd_i.clear) begin
        n_q <= '0; i_q <= '0; qcnt_q <= '0; head_q <= '0; clk_q <= '0; ovf_q <= 1'b0;
      end
    end
  end

  // Tables; wait_q and tat_q cleared at load of each entry; the job clear leaves them.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && n_q != CntW'(MaxProcs)) begin
      arr_q[n_q[IdxW-1:0]]  <= req_i.arrival_time;
      rem_q[n_q[IdxW-1:0]]  <= req_i.burst_time;
      wait_q[n_q[IdxW-1:0]] <= '0;
      tat_q[n_q[IdxW-1:0]]  <= '0;
    end
    if (cmd_i.sort_shift) order_q[j_q[IdxW-1:0]] <= prev;
    if (cmd_i.sort_place) order_q[j_q[IdxW-1:0]] <= v_q;
    if (cmd_i.enq) begin
      rdy_q[order_q[i_idx]] <= TimeW'(arr_q[order_q[i_idx]]);
      rq_q[tail]            <= order_q[i_idx];
    end
    if (cmd_i.deq) begin
      if (clk_q > rdy_q[id]) wait_q[id] <= wait_q[id] + clk_q - rdy_q[id];
      if (fin) tat_q[id] <= end_t - TimeW'(arr_q[id]);
      else begin
        rem_q[id]  <= rem_q[id] - q_eff;
        rdy_q[id]  <= end_t;
        rq_q[tail] <= id;
      end
    end
  end

  // Requeue keeps occupancy, so tail write on a preempted dispatch stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deq |-> qcnt_q != '0) else $error("dispatch from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= CntW'(MaxProcs)) else $error("queue over capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MaxProcs)) else $error("process count over capacity");
endmodule

// ----- rtl/core/rrs_ctrl.sv -----
// Controller: load, sort, enqueue, simulate and emit sequencing.
module rrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rrs_pkg::sts_t sts_i,
  output rrs_pkg::cmd_t cmd_o
);
  import rrs_pkg::*;
  typedef enum logic [2:0] {
    StLoad, StSortInit, StSortCmp, StEnq, StRun, StEmit
  } state_e;
  state_e state_q;

  always_comb begin
    cmd_o = '0;
    in_ready_o  = (state_q == StLoad);
    out_valid_o = (state_q == StEmit);
    unique case (state_q)
      StLoad:     cmd_o.load = in_valid_i;
      StSortInit: if (!sts_i.sort_done) cmd_o.sort_init = 1'b1;
      StSortCmp: begin
        if (sts_i.ins_go) cmd_o.sort_shift = 1'b1;
        else cmd_o.sort_place = 1'b1;
      end
      StEnq:      cmd_o.enq = !sts_i.enq_done;
      StRun:      cmd_o.deq = !sts_i.q_empty;
      StEmit: begin
        cmd_o.emit_next = out_ready_i && !sts_i.emit_last;
        cmd_o.clear     = out_ready_i && sts_i.emit_last;
      end
      default: ;
    endcase
    // i is reused; reset it before sort, enqueue and emission phases.
    if (state_q == StSortInit && sts_i.sort_done) cmd_o.emit_init = 1'b1;
    if (state_q == StRun && sts_i.q_empty) cmd_o.emit_init = 1'b1;
    if (state_q == StLoad && in_valid_i && in_last_i) cmd_o.emit_init = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      unique case (state_q)
        StLoad:     if (in_valid_i && in_last_i) state_q <= StSortInit;
        StSortInit: state_q <= sts_i.sort_done ? StEnq : StSortCmp;
        StSortCmp:  if (!sts_i.ins_go) state_q <= StSortInit;
        StEnq:      if (sts_i.enq_done) state_q <= StRun;
        StRun: begin
          if (sts_i.q_empty) state_q <= sts_i.empty_job ? StLoad : StEmit;
        end
        StEmit:     if (out_ready_i && sts_i.emit_last) state_q <= StLoad;
        default:    state_q <= StLoad;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("load and emit overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && !out_ready_i) |=> state_q == StEmit) else $error("stalled result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.deq |-> state_q == StRun) else $error("dispatch outside run");
endmodule
